>>> src/fwdf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fwdf_pkg - shared types and constants of the decimal formatter
// widths, ascii codes, the power-of-ten table and the sequencer states
// ----------------------------------------------------------------------------
package fwdf_pkg;

  localparam int VALUE_W        = 32;
  localparam int COUNT_W        = 4;
  localparam int CHAR_W         = 6;
  localparam int OP_W           = 34;
  localparam int MAX_DIGITS_DEF = 9;

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 6'd48;
  localparam logic [CHAR_W-1:0] CHAR_NINE  = 6'd57;
  localparam logic [CHAR_W-1:0] CHAR_POINT = 6'd46;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SIZE,
    S_CLAMP,
    S_DIGIT,
    S_PWAIT,
    S_DWAIT
  } fwdf_state_t;

  // result of the shared subtract / compare unit
  typedef struct packed {
    logic               ge;
    logic [VALUE_W-1:0] diff;
  } sub_result_t;

  function automatic logic [OP_W-1:0] pow10(input logic [COUNT_W-1:0] e);
    logic [OP_W-1:0] r;
    case (e)
      4'd0:    r = 34'd1;
      4'd1:    r = 34'd10;
      4'd2:    r = 34'd100;
      4'd3:    r = 34'd1000;
      4'd4:    r = 34'd10000;
      4'd5:    r = 34'd100000;
      4'd6:    r = 34'd1000000;
      4'd7:    r = 34'd10000000;
      4'd8:    r = 34'd100000000;
      4'd9:    r = 34'd1000000000;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

>>> src/fwdf_sub_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fwdf_sub_unit - shared subtract and compare unit
// compares the working value against an operand and gives the difference
// ----------------------------------------------------------------------------
module fwdf_sub_unit (
  input  wire logic [fwdf_pkg::VALUE_W-1:0] a,
  input  wire logic [fwdf_pkg::OP_W-1:0]    b,
  output fwdf_pkg::sub_result_t             res
);
  import fwdf_pkg::*;

  logic [OP_W:0] sum;

  // extra top bit holds the borrow
  assign sum      = {{(OP_W + 1 - VALUE_W){1'b0}}, a} - {1'b0, b};
  assign res.ge   = ~sum[OP_W];
  assign res.diff = sum[VALUE_W-1:0];

endmodule
`default_nettype wire

>>> src/fixed_width_decimal_formatter.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fixed_width_decimal_formatter - binary to ascii decimal character stream
// takes an unsigned value, a digit count and a point position and sends the
// decimal characters most significant first, with a point and a last flag
// ----------------------------------------------------------------------------
//
//  channel  | signals                                   | direction
//  ---------+-------------------------------------------+-----------
//  in       | in_valid, in_stall, value, digit_count,   | into block
//           | point_position                            |
//  out      | out_valid, out_stall, character, last     | out of block
//
// one input transaction at a time; in_stall stays high from acceptance until
// the last character transaction has been taken
// steps: load, then up to MAX_DIGITS width probes in automatic mode, then clamp
// and saturate, then 4 compare steps and an output transaction per digit; the
// point goes out as a transaction of its own
// all compares go through the one subtract / compare unit against 2^k * 10^i
// reset clears the sequencer and the output valid; no item is in flight after
// out_stall holds the current character; the sequencer waits on it

module fixed_width_decimal_formatter #(
  parameter int MAX_DIGITS = fwdf_pkg::MAX_DIGITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [fwdf_pkg::VALUE_W-1:0]    value,
  input  wire logic [fwdf_pkg::COUNT_W-1:0]    digit_count,
  input  wire logic [fwdf_pkg::COUNT_W-1:0]    point_position,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic [fwdf_pkg::CHAR_W-1:0]          character,
  output logic                                 last
);
  import fwdf_pkg::*;

  localparam logic [COUNT_W-1:0] MAX_N = COUNT_W'(MAX_DIGITS);

  fwdf_state_t state, state_next;

  logic [VALUE_W-1:0] val, val_next;          // remaining value
  logic [COUNT_W-1:0] width_n, width_n_next;  // digit count in use
  logic [COUNT_W-1:0] point_p, point_p_next;  // digits after the point
  logic [COUNT_W-1:0] idx, idx_next;          // current digit position
  logic [1:0]         bit_k, bit_k_next;      // weight step 8/4/2/1
  logic [COUNT_W-1:0] digit, digit_next;
  logic [CHAR_W-1:0]  ch_next;
  logic               last_next;
  logic               out_valid_next;

  logic [COUNT_W-1:0] op_sel;
  logic [1:0]         op_shift;
  logic [OP_W-1:0]    operand;
  sub_result_t        sub;

  // operand mux for the shared unit: 10^width in sizing, 2^k * 10^idx in digits
  always_comb begin
    op_sel   = width_n;
    op_shift = 2'd0;
    if (state == S_DIGIT) begin
      op_sel   = idx;
      op_shift = bit_k;
    end
  end

  assign operand = pow10(op_sel) << op_shift;

  fwdf_sub_unit u_sub (
    .a   (val),
    .b   (operand),
    .res (sub)
  );

  assign in_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    val       <= val_next;
    width_n   <= width_n_next;
    point_p   <= point_p_next;
    idx       <= idx_next;
    bit_k     <= bit_k_next;
    digit     <= digit_next;
    character <= ch_next;
    last      <= last_next;
  end

  always_comb begin
    logic               out_take;
    logic               enter;
    logic [COUNT_W-1:0] digit_now;

    out_take       = out_valid && !out_stall;
    enter          = 1'b0;
    digit_now      = digit | (sub.ge ? (COUNT_W'(1) << bit_k) : '0);

    state_next     = state;
    val_next       = val;
    width_n_next   = width_n;
    point_p_next   = point_p;
    idx_next       = idx;
    bit_k_next     = bit_k;
    digit_next     = digit;
    ch_next        = character;
    last_next      = last;
    out_valid_next = out_valid && !out_take;

    case (state)
      S_IDLE: begin
        if (in_valid) begin
          val_next     = value;
          point_p_next = point_position;
          if (digit_count == '0) begin
            width_n_next = COUNT_W'(1);
            state_next   = S_SIZE;
          end else begin
            width_n_next = (digit_count > MAX_N) ? MAX_N : digit_count;
            state_next   = S_CLAMP;
          end
        end
      end

      // automatic width: one more digit while value >= 10^width, up to MAX_DIGITS
      S_SIZE: begin
        if (sub.ge && width_n < MAX_N) begin
          width_n_next = width_n + COUNT_W'(1);
        end else begin
          state_next = S_CLAMP;
        end
      end

      // saturate to all nines if the value does not fit, clamp the point below the width
      S_CLAMP: begin
        if (sub.ge) begin
          val_next = VALUE_W'(pow10(width_n) - OP_W'(1));
        end
        if (point_p >= width_n) begin
          point_p_next = width_n - COUNT_W'(1);
        end
        idx_next = width_n - COUNT_W'(1);
        enter    = 1'b1;
      end

      // one binary weight of the current digit per cycle
      S_DIGIT: begin
        if (sub.ge) begin
          val_next = sub.diff;
        end
        if (bit_k == 2'd0) begin
          ch_next        = CHAR_ZERO + CHAR_W'(digit_now);
          last_next      = (idx == '0);
          out_valid_next = 1'b1;
          state_next     = S_DWAIT;
        end else begin
          bit_k_next = bit_k - 2'd1;
          digit_next = digit_now;
        end
      end

      S_PWAIT: begin
        if (out_take) begin
          bit_k_next = 2'd3;
          digit_next = '0;
          state_next = S_DIGIT;
        end
      end

      S_DWAIT: begin
        if (out_take) begin
          if (idx == '0) begin
            state_next = S_IDLE;
          end else begin
            idx_next = idx - COUNT_W'(1);
            enter    = 1'b1;
          end
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase

    // start of a digit: the point goes out first when this digit opens the fraction
    if (enter) begin
      if (point_p_next != '0 && idx_next == point_p_next - COUNT_W'(1)) begin
        ch_next        = CHAR_POINT;
        last_next      = 1'b0;
        out_valid_next = 1'b1;
        state_next     = S_PWAIT;
      end else begin
        bit_k_next = 2'd3;
        digit_next = '0;
        state_next = S_DIGIT;
      end
    end
  end

  // output valid is only high in the two waiting states
  a_valid_state: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (state == S_PWAIT || state == S_DWAIT))
    else $error("output valid outside a wait state");

  // a point is never the final character
  a_point_not_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && last) |-> (character != CHAR_POINT))
    else $error("point marked as last character");

  // characters are digits or the point
  a_char_range: assert property (@(posedge clk) disable iff (rst)
    (out_valid && character != CHAR_POINT) |->
      (character >= CHAR_ZERO && character <= CHAR_NINE))
    else $error("character out of range");

  // digit position stays inside the chosen width
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIGIT) |-> (idx < width_n && width_n <= MAX_N))
    else $error("digit position beyond width");

  // remaining value stays below ten times the current weight
  a_val_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIGIT && bit_k == 2'd3) |->
      ({2'b00, val} < (pow10(idx) << 3) + (pow10(idx) << 1)))
    else $error("digit would exceed nine");

endmodule
`default_nettype wire

>>> test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb - self-checking bench of the fixed width decimal formatter
// numbers are sent with random gaps and the character stream is compared with
// a local prediction; directed corners first, then random numbers, then a long
// receiver hold-off that fills the block and holds off its input
// ----------------------------------------------------------------------------
module tb;

  import fwdf_pkg::*;

  localparam int NUM_DIGITS   = MAX_DIGITS_DEF;
  localparam int RANDOM_ITEMS = 100;
  localparam int HOLD_CYCLES  = 300;
  localparam int IDLE_LIMIT   = 4000;
  localparam int DRAIN_CYCLES = 80;
  localparam int PRINT_CAP    = 50;

  typedef struct packed {
    logic [CHAR_W-1:0] character;
    logic              last;
  } char_txn_t;

  logic                clk;
  logic                rst;
  logic                in_valid;
  logic                in_stall;
  logic [VALUE_W-1:0]  value;
  logic [COUNT_W-1:0]  digit_count;
  logic [COUNT_W-1:0]  point_position;
  logic                out_valid;
  logic                out_stall;
  logic [CHAR_W-1:0]   character;
  logic                last;

  char_txn_t           expected_chars[$];
  int                  err_count;
  int                  numbers_sent;
  int                  chars_checked;
  int                  saturated_count;
  int                  pointed_count;
  bit                  idle_en;
  bit                  hold_req;
  int                  idle_cycles;

  fixed_width_decimal_formatter #(
    .MAX_DIGITS(NUM_DIGITS)
  ) i_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .value         (value),
    .digit_count   (digit_count),
    .point_position(point_position),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .character     (character),
    .last          (last)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // 10^k in 64 bits
  function automatic longint unsigned ten_pow(input int k);
    longint unsigned r;
    r = 1;
    for (int i = 0; i < k; i++) r = r * 10;
    return r;
  endfunction

  // gap length: mostly none or short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!idle_en || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  task automatic report_mismatch(input string what, input int got, input int exp);
    if (err_count < PRINT_CAP)
      $display("tb: mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, exp);
    err_count++;
  endtask

  // work out the character stream of one number and queue it
  task automatic predict_number(input logic [VALUE_W-1:0] v, input logic [COUNT_W-1:0] n_in,
                                input logic [COUNT_W-1:0] p_in);
    longint unsigned rem;
    longint unsigned lim;
    int              width;
    int              pos;
    int              total;
    int              k;
    int              digs[NUM_DIGITS];
    char_txn_t       c;
    width = int'(n_in);
    pos   = int'(p_in);
    rem   = {32'd0, v};
    if (width == 0) begin
      width = 1;
      while (rem >= 10) begin
        rem = rem / 10;
        width++;
      end
      rem = {32'd0, v};
    end
    if (width > NUM_DIGITS) width = NUM_DIGITS;
    if (pos >= width) pos = width - 1;
    lim = ten_pow(width);
    if (rem >= lim) begin
      rem = lim - 1;
      saturated_count++;
    end
    for (int d = 0; d < width; d++) begin
      digs[d] = int'(rem % 10);
      rem = rem / 10;
    end
    total = width + ((pos != 0) ? 1 : 0);
    if (pos != 0) pointed_count++;
    k = 0;
    for (int d = width; d > 0; d--) begin
      if (pos != 0 && d == pos) begin
        c.character = CHAR_POINT;
        c.last      = 1'b0;
        expected_chars.push_back(c);
        k++;
      end
      c.character = CHAR_ZERO + CHAR_W'(digs[d-1]);
      c.last      = (k == total - 1);
      expected_chars.push_back(c);
      k++;
    end
  endtask

  // offer one number and wait for its transaction; returns at the next falling edge
  task automatic send_number(input logic [VALUE_W-1:0] v, input logic [COUNT_W-1:0] n,
                             input logic [COUNT_W-1:0] p);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    value          = v;
    digit_count    = n;
    point_position = p;
    in_valid       = 1'b1;
    do @(posedge clk); while (in_stall);
    predict_number(v, n, p);
    numbers_sent++;
    @(negedge clk);
  endtask

  // every character transaction against the oldest expectation
  always @(posedge clk) begin
    char_txn_t exp_c;
    if (!rst && out_valid && !out_stall) begin
      chars_checked++;
      if (expected_chars.size() == 0) begin
        report_mismatch("unexpected character", int'(character), 0);
      end else begin
        exp_c = expected_chars.pop_front();
        if (character !== exp_c.character)
          report_mismatch("character", int'(character), int'(exp_c.character));
        if (last !== exp_c.last)
          report_mismatch("last", int'(last), int'(exp_c.last));
      end
    end
  end

  // receiver side: random stalls, or one long hold-off on request
  initial begin
    int len;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req  = 1'b0;
        out_stall = 1'b0;
      end else begin
        len = pick_gap();
        if (len > 0) begin
          out_stall = 1'b1;
          repeat (len) @(negedge clk);
          out_stall = 1'b0;
        end
      end
    end
  end

  // watchdog on cycles with no transaction on either side
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("tb: done, errors");
        $finish;
      end
    end
  end

  task automatic test_auto_width();
    send_number(32'd0, 4'd0, 4'd0);
    send_number(32'd9, 4'd0, 4'd0);
    send_number(32'd10, 4'd0, 4'd0);
    send_number(32'd999999999, 4'd0, 4'd0);
    send_number(32'd1000000000, 4'd0, 4'd0);   // ten digits saturate to nine nines
    send_number(32'hFFFF_FFFF, 4'd0, 4'd0);
  endtask

  task automatic test_fixed_width();
    send_number(32'd0, 4'd1, 4'd0);
    send_number(32'd42, 4'd5, 4'd0);           // leading zeros
    send_number(32'd12345, 4'd3, 4'd0);        // does not fit, all nines
    send_number(32'd1000, 4'd3, 4'd0);         // exactly 10^width
    send_number(32'hFFFF_FFFF, 4'd9, 4'd0);
    send_number(32'd123, 4'd15, 4'd0);         // count above the maximum
    send_number(32'd1234567890, 4'd10, 4'd0);
  endtask

  task automatic test_decimal_point();
    send_number(32'd12345, 4'd5, 4'd2);
    send_number(32'd12345, 4'd5, 4'd4);
    send_number(32'd12345, 4'd5, 4'd5);        // clamped to width - 1
    send_number(32'd7, 4'd3, 4'd15);
    send_number(32'd5, 4'd1, 4'd3);            // one digit never shows a point
    send_number(32'd7, 4'd0, 4'd1);
    send_number(32'd123456, 4'd0, 4'd8);
    send_number(32'hFFFF_FFFF, 4'd9, 4'd8);
    send_number(32'd3, 4'd9, 4'd8);
  endtask

  task automatic test_random_numbers();
    logic [VALUE_W-1:0] v;
    logic [COUNT_W-1:0] n;
    logic [COUNT_W-1:0] p;
    int                 k;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      // a stretch with no idling on either side
      if (i == 40) idle_en = 1'b0;
      if (i == 70) idle_en = 1'b1;
      case ($urandom_range(0, 4))
        0: v = $urandom;
        1: v = $urandom_range(0, 999);
        2: begin
          k = $urandom_range(1, 9);
          v = VALUE_W'(ten_pow(k) + $urandom_range(0, 2) - 1);
        end
        3: v = $urandom_range(0, 99999999);
        default: v = $urandom_range(0, 9);
      endcase
      if ($urandom_range(0, 3) == 0) n = 4'd0;
      else if ($urandom_range(0, 9) == 0) n = COUNT_W'($urandom_range(10, 15));
      else n = COUNT_W'($urandom_range(1, 9));
      k = $urandom_range(0, 9);
      if (k < 4) p = 4'd0;
      else if (k < 9) p = COUNT_W'($urandom_range(1, 8));
      else p = COUNT_W'($urandom_range(9, 15));
      send_number(v, n, p);
    end
  endtask

  // receiver holds off while numbers keep coming, so the input backs up
  task automatic test_output_hold();
    hold_req = 1'b1;
    for (int i = 0; i < 6; i++)
      send_number($urandom, COUNT_W'($urandom_range(0, 9)), COUNT_W'($urandom_range(0, 8)));
  endtask

  initial begin
    rst            = 1'b1;
    in_valid       = 1'b0;
    value          = '0;
    digit_count    = '0;
    point_position = '0;
    err_count       = 0;
    numbers_sent    = 0;
    chars_checked   = 0;
    saturated_count = 0;
    pointed_count   = 0;
    idle_en         = 1'b1;
    hold_req        = 1'b0;
    idle_cycles     = 0;
    repeat (2) @(negedge clk);
    rst = 1'b0;

    test_auto_width();
    test_fixed_width();
    test_decimal_point();
    test_random_numbers();
    test_output_hold();

    in_valid = 1'b0;
    while (expected_chars.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_chars.size() != 0)
      report_mismatch("leftover characters", expected_chars.size(), 0);

    $display("tb: %0d numbers formatted, %0d characters checked", numbers_sent, chars_checked);
    $display("tb: %0d saturated, %0d with a point, %0d mismatches",
             saturated_count, pointed_count, err_count);
    if (err_count == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
